// ===== hdl/bilinear_texture_sampler_assert.svh =====
// assertion macros for the texture sampler
`ifndef BILINEAR_TEXTURE_SAMPLER_ASSERT_SVH
`define BILINEAR_TEXTURE_SAMPLER_ASSERT_SVH

// plain property, checked on every rising clock edge outside reset
`define BTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// overlapping implication from a condition to a consequence
`define BTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/bts_pkg.sv =====
`default_nettype none
package bts_pkg;

  // fixed sizes of the texture store and the texture
  localparam int unsigned DIM_MAX     = 256;
  localparam int unsigned TEXEL_COUNT = 65536;
  localparam int unsigned DIM_W       = 9;
  localparam int unsigned COORD_W     = 8;
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned TEXEL_W     = 24;
  localparam int unsigned CFG_DATA_W  = 9;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [15:0] WHITE_OUT = 16'hFF00;

  // operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEX_WIDTH  = 2'd0,
    CFG_TEX_HEIGHT = 2'd1,
    CFG_CHANNELS   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic        opcode;
    logic [15:0] texel_index;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic signed [31:0] u_coord;
    logic signed [31:0] v_coord;
  } in_item_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
  } out_item_t;

endpackage
`default_nettype wire

// ===== hdl/bilinear_texture_sampler.sv =====
// items pass through capture, scaling, addressing, texel read, horizontal and vertical blend
// throughput: one item per cycle unless the output stalls; the four texel reads come from two
// copies of the texel store, each with two read ports, written together
// a stall at the output holds every stage; write items give no result
// reset clears the pipeline valid bits and the configuration registers
// the texel store is not cleared by reset
`default_nettype none
module bilinear_texture_sampler (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire bts_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output bts_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire logic [bts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bts_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import bts_pkg::*;

  // configuration registers
  logic [DIM_W-1:0] tex_width_r;
  logic [DIM_W-1:0] tex_height_r;
  logic [2:0]       channel_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r     <= '0;
      tex_height_r    <= '0;
      channel_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEX_WIDTH:  tex_width_r     <= cfg_wdata;
        CFG_TEX_HEIGHT: tex_height_r    <= cfg_wdata;
        CFG_CHANNELS:   channel_count_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // derived texture geometry; keep it stable while items are in flight (the block does not enforce it)
  logic [DIM_W-1:0]   w_c, h_c;
  logic [COORD_W-1:0] wm1_c, hm1_c;
  logic               white_c, grey_c;

  always_comb begin
    w_c     = (tex_width_r  > DIM_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : tex_width_r;
    h_c     = (tex_height_r > DIM_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : tex_height_r;
    wm1_c   = COORD_W'(w_c - DIM_W'(1));
    hm1_c   = COORD_W'(h_c - DIM_W'(1));
    white_c = (w_c == '0) || (h_c == '0) || (channel_count_r == '0);
    grey_c  = (channel_count_r <= 3'd2);
  end

  // pipeline advance
  logic out_valid_r;
  logic adv_c;
  assign adv_c    = !out_valid_r || out_ready;
  assign in_ready = adv_c;

  // stage 1: captured item
  logic        v1_r;
  logic        op1_r;
  logic [15:0] idx1_r;
  logic [TEXEL_W-1:0] wd1_r;
  logic [15:0] fu1_r, fv1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv_c) v1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv_c) begin
      op1_r  <= in_data.opcode;
      idx1_r <= in_data.texel_index;
      wd1_r  <= {in_data.blue_in, in_data.green_in, in_data.red_in};
      fu1_r  <= in_data.u_coord[15:0];
      fv1_r  <= in_data.v_coord[15:0];
    end
  end

  // stage 2: scaled positions
  logic        v2_r, op2_r;
  logic [15:0] idx2_r;
  logic [TEXEL_W-1:0] wd2_r;
  logic [23:0] px2_r, px2_nxt;
  logic [24:0] py2_r, py2_nxt;
  logic [16:0] fvc_c;

  always_comb begin
    fvc_c   = 17'h10000 - {1'b0, fv1_r};
    px2_nxt = {8'b0, fu1_r} * {16'b0, wm1_c};
    py2_nxt = {8'b0, fvc_c} * {17'b0, hm1_c};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv_c) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (adv_c) begin
      op2_r  <= op1_r;
      idx2_r <= idx1_r;
      wd2_r  <= wd1_r;
      px2_r  <= px2_nxt;
      py2_r  <= py2_nxt;
    end
  end

  // stage 3: neighbour coordinates and store addresses
  logic        v3_r, op3_r;
  logic [15:0] idx3_r;
  logic [TEXEL_W-1:0] wd3_r;
  logic [ADDR_W-1:0] a00_r, a10_r, a01_r, a11_r;
  logic [ADDR_W-1:0] a00_nxt, a10_nxt, a01_nxt, a11_nxt;
  logic [15:0] tx3_r, ty3_r;
  logic [COORD_W-1:0] x0_c, x1_c, y0_c, y1_c;
  logic [COORD_W:0]   y0_raw_c;
  logic [16:0] row0_c, row1_c;

  always_comb begin
    x0_c     = (px2_r[23:16] > wm1_c) ? wm1_c : px2_r[23:16];
    y0_raw_c = py2_r[24:16];
    y0_c     = (y0_raw_c > {1'b0, hm1_c}) ? hm1_c : y0_raw_c[COORD_W-1:0];
    x1_c     = (x0_c < wm1_c) ? COORD_W'(x0_c + 1'b1) : wm1_c;
    y1_c     = (y0_c < hm1_c) ? COORD_W'(y0_c + 1'b1) : hm1_c;
    row0_c   = {9'b0, y0_c} * {8'b0, w_c};
    row1_c   = {9'b0, y1_c} * {8'b0, w_c};
    a00_nxt  = ADDR_W'(row0_c + {9'b0, x0_c});
    a10_nxt  = ADDR_W'(row0_c + {9'b0, x1_c});
    a01_nxt  = ADDR_W'(row1_c + {9'b0, x0_c});
    a11_nxt  = ADDR_W'(row1_c + {9'b0, x1_c});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv_c) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (adv_c) begin
      op3_r  <= op2_r;
      idx3_r <= idx2_r;
      wd3_r  <= wd2_r;
      a00_r  <= a00_nxt;
      a10_r  <= a10_nxt;
      a01_r  <= a01_nxt;
      a11_r  <= a11_nxt;
      tx3_r  <= px2_r[15:0];
      ty3_r  <= py2_r[15:0];
    end
  end

  // stage 4: texel store, two copies for the top and bottom rows
  logic [TEXEL_W-1:0] top_mem_r [TEXEL_COUNT];
  logic [TEXEL_W-1:0] bot_mem_r [TEXEL_COUNT];
  logic [TEXEL_W-1:0] t00_r, t10_r, t01_r, t11_r;
  logic               v4_r;
  logic [15:0]        tx4_r, ty4_r;
  logic               wr_c;

  assign wr_c = adv_c && v3_r && (op3_r == OP_WRITE);

  always_ff @(posedge clk) begin
    if (wr_c) top_mem_r[idx3_r] <= wd3_r;
    if (adv_c) begin
      t00_r <= top_mem_r[a00_r];
      t10_r <= top_mem_r[a10_r];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_c) bot_mem_r[idx3_r] <= wd3_r;
    if (adv_c) begin
      t01_r <= bot_mem_r[a01_r];
      t11_r <= bot_mem_r[a11_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv_c) v4_r <= v3_r && (op3_r == OP_SAMPLE);
  end

  always_ff @(posedge clk) begin
    if (adv_c) begin
      tx4_r <= tx3_r;
      ty4_r <= ty3_r;
    end
  end

  // stage 5: horizontal blend per channel
  logic              v5_r;
  logic [15:0]       ty5_r;
  logic [2:0][23:0]  top5_r, bot5_r, top5_nxt, bot5_nxt;
  logic [16:0]       txc_c;
  logic [7:0]        c00, c10, c01, c11;

  always_comb begin
    txc_c = 17'h10000 - {1'b0, tx4_r};
    for (int ch = 0; ch < 3; ch++) begin
      c00 = grey_c ? t00_r[7:0] : t00_r[8*ch +: 8];
      c10 = grey_c ? t10_r[7:0] : t10_r[8*ch +: 8];
      c01 = grey_c ? t01_r[7:0] : t01_r[8*ch +: 8];
      c11 = grey_c ? t11_r[7:0] : t11_r[8*ch +: 8];
      top5_nxt[ch] = {16'b0, c00} * {7'b0, txc_c} + {16'b0, c10} * {8'b0, tx4_r};
      bot5_nxt[ch] = {16'b0, c01} * {7'b0, txc_c} + {16'b0, c11} * {8'b0, tx4_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (adv_c) v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (adv_c) begin
      ty5_r  <= ty4_r;
      top5_r <= top5_nxt;
      bot5_r <= bot5_nxt;
    end
  end

  // stage 6: vertical blend into the output register, or white when no texture is set
  out_item_t  out_data_r, out_data_nxt;
  logic [16:0] tyc_c;
  logic [39:0] mix_c [3];

  always_comb begin
    tyc_c = 17'h10000 - {1'b0, ty5_r};
    for (int ch = 0; ch < 3; ch++) begin
      mix_c[ch] = 40'({16'b0, top5_r[ch]} * {23'b0, tyc_c}
                    + {16'b0, bot5_r[ch]} * {24'b0, ty5_r});
    end
    if (white_c) begin
      out_data_nxt = '{red_out: WHITE_OUT, green_out: WHITE_OUT, blue_out: WHITE_OUT};
    end else begin
      out_data_nxt = '{red_out: mix_c[0][39:24], green_out: mix_c[1][39:24],
                       blue_out: mix_c[2][39:24]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv_c) out_valid_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    if (adv_c) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `include "bilinear_texture_sampler_assert.svh"

  `BTS_ASSERT_IMP(a_out_from_pipe, $rose(out_valid_r), $past(v5_r), "result without a sample in the last stage")
  `BTS_ASSERT(a_stall_holds, !$past(adv_c) |-> ($stable(v5_r) && $stable(v4_r) && $stable(out_valid_r)), "pipeline moved during a stall")
  `BTS_ASSERT_IMP(a_out_range, out_valid_r, (out_data_r.red_out <= WHITE_OUT) && (out_data_r.green_out <= WHITE_OUT) && (out_data_r.blue_out <= WHITE_OUT), "result above white")

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import bts_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned LONG_HOLD      = 400;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bilinear_texture_sampler uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // predictor state: its own texel store and register copies
  logic [23:0] texel_mem [0:TEXEL_COUNT-1];
  int unsigned tex_w_reg, tex_h_reg, chan_reg;

  // generator view of the store and of the current texture
  bit          texel_known [0:TEXEL_COUNT-1];
  int unsigned gen_w, gen_h, gen_chan;

  in_item_t    item_backlog[$];
  out_item_t   expected_colours[$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned results_seen;
  bit          item_taken;
  int unsigned send_gap;
  int unsigned hold_left;
  bit          long_hold_done;
  bit          steady_send;
  bit          steady_recv;

  // four row-major neighbour indexes and weights of one sample
  function automatic void texel_quad(input logic [15:0] fu, input logic [15:0] fv,
                                     input int unsigned w, input int unsigned h,
                                     output logic [3:0][15:0] idx,
                                     output longint unsigned tx, output longint unsigned ty);
    longint unsigned px, py, x0, y0, x1, y1;
    px = longint'(fu) * (w - 1);
    py = (64'd65536 - longint'(fv)) * (h - 1);
    x0 = px >> 16;
    y0 = py >> 16;
    tx = px & 64'hFFFF;
    ty = py & 64'hFFFF;
    if (x0 > w - 1) x0 = w - 1;
    if (y0 > h - 1) y0 = h - 1;
    x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
    y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
    idx[0] = 16'((y0 * w + x0) % TEXEL_COUNT);
    idx[1] = 16'((y0 * w + x1) % TEXEL_COUNT);
    idx[2] = 16'((y1 * w + x0) % TEXEL_COUNT);
    idx[3] = 16'((y1 * w + x1) % TEXEL_COUNT);
  endfunction

  function automatic int unsigned sat_dim(input int unsigned d);
    return (d > DIM_MAX) ? DIM_MAX : d;
  endfunction

  // filtered colour of one sample from the predictor's store
  function automatic out_item_t filtered_colour(input in_item_t it);
    out_item_t        res;
    int unsigned      w, h;
    logic [3:0][15:0] idx;
    longint unsigned  tx, ty, top, bot, mix;
    longint unsigned  c00, c10, c01, c11;
    logic [15:0]      chan_val [3];
    bit               grey;
    w = sat_dim(tex_w_reg);
    h = sat_dim(tex_h_reg);
    if (w == 0 || h == 0 || chan_reg == 0) begin
      res.red_out   = WHITE_OUT;
      res.green_out = WHITE_OUT;
      res.blue_out  = WHITE_OUT;
      return res;
    end
    texel_quad(it.u_coord[15:0], it.v_coord[15:0], w, h, idx, tx, ty);
    grey = (chan_reg <= 2);
    for (int c = 0; c < 3; c++) begin
      c00 = grey ? texel_mem[idx[0]][7:0] : texel_mem[idx[0]][8*c +: 8];
      c10 = grey ? texel_mem[idx[1]][7:0] : texel_mem[idx[1]][8*c +: 8];
      c01 = grey ? texel_mem[idx[2]][7:0] : texel_mem[idx[2]][8*c +: 8];
      c11 = grey ? texel_mem[idx[3]][7:0] : texel_mem[idx[3]][8*c +: 8];
      top = c00 * (65536 - tx) + c10 * tx;
      bot = c01 * (65536 - tx) + c11 * tx;
      mix = top * (65536 - ty) + bot * ty;
      chan_val[c] = 16'(mix >> 24);
    end
    res.red_out   = chan_val[0];
    res.green_out = chan_val[1];
    res.blue_out  = chan_val[2];
    return res;
  endfunction

  // gaps: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // item queueing for the generator
  task automatic queue_write(input logic [15:0] idx, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b);
    in_item_t it;
    it.opcode      = OP_WRITE;
    it.texel_index = idx;
    it.red_in      = r;
    it.green_in    = g;
    it.blue_in     = b;
    it.u_coord     = $urandom;
    it.v_coord     = $urandom;
    texel_known[idx] = 1'b1;
    item_backlog.push_back(it);
  endtask

  // a sample, preceded by writes of any neighbour not yet written
  task automatic queue_sample(input logic [31:0] u, input logic [31:0] v);
    in_item_t         it;
    logic [3:0][15:0] idx;
    longint unsigned  tx, ty;
    int unsigned      w, h;
    w = sat_dim(gen_w);
    h = sat_dim(gen_h);
    if (w != 0 && h != 0 && gen_chan != 0) begin
      texel_quad(u[15:0], v[15:0], w, h, idx, tx, ty);
      for (int k = 0; k < 4; k++)
        if (!texel_known[idx[k]])
          queue_write(idx[k], 8'($urandom), 8'($urandom), 8'($urandom));
    end
    it.opcode      = OP_SAMPLE;
    it.texel_index = 16'($urandom);
    it.red_in      = 8'($urandom);
    it.green_in    = 8'($urandom);
    it.blue_in     = 8'($urandom);
    it.u_coord     = u;
    it.v_coord     = v;
    item_backlog.push_back(it);
  endtask

  task automatic write_reg(input cfg_reg_t r, input int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_texture(input int unsigned w, input int unsigned h, input int unsigned ch);
    write_reg(CFG_TEX_WIDTH, w);
    write_reg(CFG_TEX_HEIGHT, h);
    write_reg(CFG_CHANNELS, ch);
    gen_w    = w;
    gen_h    = h;
    gen_chan = ch;
  endtask

  // let the backlog run dry and the pipeline empty
  task automatic drain();
    while (item_backlog.size() != 0 || in_valid || expected_colours.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // coordinate with a random or edge fraction
  function automatic logic [31:0] pick_coord();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return {16'($urandom_range(0, 65535)), 16'h0000};
    if (r == 1) return {16'($urandom), 16'hFFFF};
    return $urandom;
  endfunction

  task automatic random_phase(input int unsigned n);
    int unsigned w, h;
    w = sat_dim(gen_w);
    h = sat_dim(gen_h);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0 && w != 0 && h != 0)
        queue_write(16'($urandom_range(0, w * h - 1)), 8'($urandom), 8'($urandom),
                    8'($urandom));
      else if ($urandom_range(0, 19) == 0)
        queue_write(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      else
        queue_sample(pick_coord(), pick_coord());
    end
    drain();
  endtask

  // monitor, predictor and watchdog on the rising edge
  always @(posedge clk) begin
    out_item_t want;
    item_taken = 1'b0;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_TEX_WIDTH:  tex_w_reg = 32'(cfg_wdata);
          CFG_TEX_HEIGHT: tex_h_reg = 32'(cfg_wdata);
          CFG_CHANNELS:   chan_reg  = 32'(cfg_wdata[2:0]);
          default: ;
        endcase
      end
      idle_cycles++;
      if (in_valid && in_ready) begin
        item_taken  = 1'b1;
        idle_cycles = 0;
        if (in_data.opcode == OP_WRITE)
          texel_mem[in_data.texel_index] = {in_data.blue_in, in_data.green_in, in_data.red_in};
        else
          expected_colours.push_back(filtered_colour(in_data));
      end
      if (out_valid && out_ready) begin
        idle_cycles = 0;
        results_seen++;
        if (expected_colours.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result r=%h g=%h b=%h", out_data.red_out,
                     out_data.green_out, out_data.blue_out);
        end else begin
          want = expected_colours.pop_front();
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("colour mismatch: want r=%h g=%h b=%h, got r=%h g=%h b=%h",
                       want.red_out, want.green_out, want.blue_out,
                       out_data.red_out, out_data.green_out, out_data.blue_out);
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // sender: presents items from the backlog with random gaps
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !item_taken)) begin
      if ($urandom_range(0, 49) == 0) steady_send = !steady_send;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (item_backlog.size() != 0) begin
        in_data  <= item_backlog.pop_front();
        in_valid <= 1'b1;
        send_gap = steady_send ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls and one long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if ($urandom_range(0, 49) == 0) steady_recv = !steady_recv;
      if (!long_hold_done && results_seen >= 60) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (steady_recv) begin
        out_ready <= 1'b1;
      end else begin
        hold_left = pick_gap();
        out_ready <= (hold_left == 0);
      end
    end
  end

  // stimulus
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    tex_w_reg = 0; tex_h_reg = 0; chan_reg = 0;
    gen_w = 0; gen_h = 0; gen_chan = 0;
    mismatches = 0; idle_cycles = 0; results_seen = 0;
    send_gap = 0; hold_left = 0; long_hold_done = 1'b0;
    steady_send = 1'b0; steady_recv = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // no texture after reset: white
    queue_sample(32'h0000_8000, 32'h0000_8000);
    queue_sample(32'hFFFF_FFFF, 32'h8000_0000);
    drain();

    // directed 4x4 colour texture with extreme red and green bytes
    set_texture(4, 4, 3);
    for (int i = 0; i < 16; i++)
      queue_write(16'(i), (i % 2) ? 8'hFF : 8'h00, (i % 3) ? 8'h00 : 8'hFF, 8'($urandom));
    queue_sample(32'h0000_0000, 32'h0000_0000);
    queue_sample(32'h0000_FFFF, 32'h0000_FFFF);
    queue_sample(32'h7FFF_FFFF, 32'h8000_0000);
    queue_sample(32'h8000_0000, 32'h7FFF_FFFF);
    queue_sample(32'hFFFF_8000, 32'h0001_4000);
    queue_sample(32'h0000_5555, 32'hFFFF_AAAA);
    drain();

    // single texel grey, then full-size, oversize, grey, empty and odd-size textures
    set_texture(1, 1, 1);
    random_phase(30);
    set_texture(256, 256, 4);
    random_phase(30);
    set_texture(511, 300, 7);
    random_phase(30);
    set_texture(2, 3, 2);
    random_phase(50);
    set_texture(5, 0, 3);
    random_phase(30);
    set_texture(3, 7, 0);
    random_phase(30);
    set_texture(17, 9, 5);
    random_phase(60);
    set_texture(256, 1, 6);
    random_phase(30);
    set_texture(1, 256, 3);
    random_phase(40);

    if (mismatches == 0 && expected_colours.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire

// ===== bilinear_texture_sampler.f =====
+incdir+hdl
hdl/bts_pkg.sv
hdl/bilinear_texture_sampler.sv
sim/tb.sv
